// ----- src/mbp_pkg.sv -----
`default_nettype none

package mbp_pkg;

    localparam int PIX_W     = 10;
    localparam int STEP_W    = 28;
    localparam int STEP_FRAC = 28;
    localparam int ITER_W    = 8;
    localparam int COLOR_W   = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 28;

    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 2'd3;

    localparam logic [PIX_W-1:0]   X_ORIGIN_RST = 10'd600;
    localparam logic [PIX_W-1:0]   Y_ORIGIN_RST = 10'd400;
    localparam logic [STEP_W-1:0]  STEP_RST     = 28'd894785;
    localparam logic [ITER_W-1:0]  MAX_ITER_RST = 8'd100;

    // colour of points that stay bounded up to the limit
    localparam logic [COLOR_W-1:0] IN_SET_RED   = 8'd255;
    localparam logic [COLOR_W-1:0] IN_SET_GREEN = 8'd200;
    localparam logic [COLOR_W-1:0] IN_SET_BLUE  = 8'd200;

    localparam longint unsigned PAL_STEP    = 64'd205069583;
    localparam longint unsigned THIRD_TURN  = 64'd1431655765;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP_X,
        ST_MAP_Y,
        ST_MAP_W,
        ST_TEST,
        ST_SQ_I,
        ST_CROSS,
        ST_UPD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic neg;
        logic map_mode;
    } mul_ctl_t;

    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic               in_set;
        logic [ITER_W-1:0]  iterations;
    } result_t;

    // sine palette channel, quadrant folded, Taylor series in Q30
    function automatic logic [COLOR_W-1:0] pal_channel(input logic [31:0] phase);
        longint unsigned r;
        longint unsigned q;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned mag;
        r = {34'd0, phase[29:0]};
        q = phase[30] ? (ONE_Q30 - r) : r;
        x = (q * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t = ONE_Q30;
        t = ONE_Q30 - ((x2 * t) >> 30) / 110;
        t = ONE_Q30 - ((x2 * t) >> 30) / 72;
        t = ONE_Q30 - ((x2 * t) >> 30) / 42;
        t = ONE_Q30 - ((x2 * t) >> 30) / 20;
        t = ONE_Q30 - ((x2 * t) >> 30) / 6;
        t = (x * t) >> 30;
        if (t > ONE_Q30) begin
            t = ONE_Q30;
        end
        mag = (t * 64'd127) >> 30;
        return phase[31] ? COLOR_W'(64'd127 - mag) : COLOR_W'(64'd127 + mag);
    endfunction

    // {blue, green, red} for palette entry k
    function automatic logic [3*COLOR_W-1:0] pal_entry(input int k);
        longint unsigned kk;
        logic [31:0] ph_r;
        logic [31:0] ph_g;
        logic [31:0] ph_b;
        kk = longint'(k);
        ph_r = 32'(kk * PAL_STEP);
        ph_g = 32'(kk * PAL_STEP + THIRD_TURN);
        ph_b = 32'(kk * PAL_STEP + 64'd2 * THIRD_TURN);
        return {pal_channel(ph_b), pal_channel(ph_g), pal_channel(ph_r)};
    endfunction

endpackage

`default_nettype wire

// ----- src/mandelbrot_pixel_shader.sv -----
// Per pixel, MAP_X, MAP_Y and MAP_W map the point to c; each iteration then
// runs TEST, SQ_I, CROSS and UPD, stopping at TEST on the limit or range test
// and at CROSS when |z|^2 >= 4. An iteration's three products share one multiplier.
// Throughput: one pixel at a time; the next input word is taken once the
// result has moved to the output register. Reset: aresetn synchronous,
// active low; clears control state and loads the default configuration.
`default_nettype none

module mandelbrot_pixel_shader #(
    parameter int PIXEL_RANGE    = 1024,
    parameter int FRAC_BITS      = 28,
    parameter int ITER_LIMIT_MAX = 255
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [23:0]                       s_tdata,  // x_pixel, y_pixel, pad
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [31:0]                            m_tdata,  // iterations, red, green, blue
    output logic [0:0]                             m_tuser,  // in_set
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mbp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mbp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [mbp_pkg::PIX_W-1:0]  x_origin_reg;
    logic [mbp_pkg::PIX_W-1:0]  y_origin_reg;
    logic [mbp_pkg::STEP_W-1:0] step_reg;
    logic [mbp_pkg::ITER_W-1:0] max_iter_reg;

    logic             core_idle;
    logic             core_valid;
    logic             core_ready;
    logic             start;
    mbp_pkg::result_t core_res;
    mbp_pkg::result_t out_reg;
    logic             m_valid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_origin_reg <= mbp_pkg::X_ORIGIN_RST;
            y_origin_reg <= mbp_pkg::Y_ORIGIN_RST;
            step_reg     <= mbp_pkg::STEP_RST;
            max_iter_reg <= mbp_pkg::MAX_ITER_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                mbp_pkg::REG_X_ORIGIN: x_origin_reg <= cfg_data[mbp_pkg::PIX_W-1:0];
                mbp_pkg::REG_Y_ORIGIN: y_origin_reg <= cfg_data[mbp_pkg::PIX_W-1:0];
                mbp_pkg::REG_STEP:     step_reg     <= cfg_data[mbp_pkg::STEP_W-1:0];
                mbp_pkg::REG_MAX_ITER: max_iter_reg <= cfg_data[mbp_pkg::ITER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready = core_idle;
    assign start    = s_tvalid && core_idle;

    mbp_core #(
        .PIXEL_RANGE    (PIXEL_RANGE),
        .FRAC_BITS      (FRAC_BITS),
        .ITER_LIMIT_MAX (ITER_LIMIT_MAX)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .x_pixel   (s_tdata[9:0]),
        .y_pixel   (s_tdata[19:10]),
        .x_origin  (x_origin_reg),
        .y_origin  (y_origin_reg),
        .step      (step_reg),
        .max_iter  (max_iter_reg),
        .idle      (core_idle),
        .res_valid (core_valid),
        .res_ready (core_ready),
        .result    (core_res)
    );

    // hand the result over when the output register is empty or draining
    assign core_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (core_valid && core_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_valid && core_ready) begin
            out_reg <= core_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_reg.blue, out_reg.green, out_reg.red, out_reg.iterations};
    assign m_tuser  = out_reg.in_set;

endmodule

`default_nettype wire

// ----- src/mbp_palette_rom.sv -----
`default_nettype none

module mbp_palette_rom #(
    parameter int DEPTH = 255,
    parameter int AW    = 8
) (
    input  wire logic                           aclk,
    input  wire logic [AW-1:0]                  addr,
    output logic [3*mbp_pkg::COLOR_W-1:0]       rd_data
);

    logic [3*mbp_pkg::COLOR_W-1:0] rom_tab [DEPTH];
    logic [3*mbp_pkg::COLOR_W-1:0] rd_data_reg;

    for (genvar k = 0; k < DEPTH; k++) begin : g_tab
        localparam logic [3*mbp_pkg::COLOR_W-1:0] ENTRY = mbp_pkg::pal_entry(k);
        assign rom_tab[k] = ENTRY;
    end

    always_ff @(posedge aclk) begin
        if ({1'b0, addr} < (AW+1)'(DEPTH)) begin
            rd_data_reg <= rom_tab[addr];
        end else begin
            rd_data_reg <= '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- src/mbp_mul_unit.sv -----
`default_nettype none

// Shared magnitude multiplier; sign, scaling and saturation follow the product register.
module mbp_mul_unit #(
    parameter int FRAC_BITS = 28,
    localparam int MA = (FRAC_BITS + 1 > mbp_pkg::STEP_FRAC) ? FRAC_BITS + 1
                                                             : mbp_pkg::STEP_FRAC
) (
    input  wire logic                     aclk,
    input  wire logic [MA-1:0]            a_mag,
    input  wire logic [MA-1:0]            b_mag,
    input  wire mbp_pkg::mul_ctl_t        ctl,
    output logic signed [FRAC_BITS+3:0]   res
);

    localparam int W    = FRAC_BITS + 4;
    localparam int SHL  = (FRAC_BITS >= mbp_pkg::STEP_FRAC) ? FRAC_BITS - mbp_pkg::STEP_FRAC : 0;
    localparam int SHR  = (FRAC_BITS >= mbp_pkg::STEP_FRAC) ? 0 : mbp_pkg::STEP_FRAC - FRAC_BITS;
    localparam int MAGW = 2 * MA + SHL;

    localparam logic [MAGW-1:0] POS_LIM = (MAGW'(1) << (FRAC_BITS + 3)) - MAGW'(1);
    localparam logic [MAGW-1:0] NEG_LIM = MAGW'(1) << (FRAC_BITS + 3);
    localparam logic signed [W-1:0] Z_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] Z_MIN = {1'b1, {(W-1){1'b0}}};

    logic [2*MA-1:0]   prod_reg;
    mbp_pkg::mul_ctl_t ctl_reg;
    logic [MAGW-1:0]   mag_w;
    logic [MAGW-1:0]   mag;

    always_ff @(posedge aclk) begin
        prod_reg <= (2*MA)'(a_mag) * (2*MA)'(b_mag);
        ctl_reg  <= ctl;
    end

    always_comb begin
        mag_w = MAGW'(prod_reg);
        if (ctl_reg.map_mode) begin
            mag = (mag_w << SHL) >> SHR;
        end else begin
            mag = mag_w >> FRAC_BITS;
        end
        if (ctl_reg.neg) begin
            res = (mag > NEG_LIM) ? Z_MIN : -$signed(W'(mag));
        end else begin
            res = (mag > POS_LIM) ? Z_MAX : $signed(W'(mag));
        end
    end

endmodule

`default_nettype wire

// ----- src/mbp_core.sv -----
`default_nettype none

module mbp_core #(
    parameter int PIXEL_RANGE    = 1024,
    parameter int FRAC_BITS      = 28,
    parameter int ITER_LIMIT_MAX = 255
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [mbp_pkg::PIX_W-1:0]     x_pixel,
    input  wire logic [mbp_pkg::PIX_W-1:0]     y_pixel,
    input  wire logic [mbp_pkg::PIX_W-1:0]     x_origin,
    input  wire logic [mbp_pkg::PIX_W-1:0]     y_origin,
    input  wire logic [mbp_pkg::STEP_W-1:0]    step,
    input  wire logic [mbp_pkg::ITER_W-1:0]    max_iter,
    output logic                               idle,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output mbp_pkg::result_t                   result
);

    localparam int W       = FRAC_BITS + 4;
    localparam int MA      = (FRAC_BITS + 1 > mbp_pkg::STEP_FRAC) ? FRAC_BITS + 1
                                                                  : mbp_pkg::STEP_FRAC;
    localparam int LIM_MAX = (ITER_LIMIT_MAX < 255) ? ITER_LIMIT_MAX : 255;
    localparam int CW      = $clog2(LIM_MAX + 1);
    localparam int IW      = $clog2(ITER_LIMIT_MAX);
    localparam int PIX_MAX = PIXEL_RANGE - 1;
    localparam int DW      = mbp_pkg::PIX_W + 1;

    localparam logic signed [W-1:0] Z_MAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] Z_MIN   = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] TWO     = {3'b001, {(FRAC_BITS+1){1'b0}}};
    localparam logic signed [W-1:0] NEG_TWO = {3'b111, {(FRAC_BITS+1){1'b0}}};
    localparam logic [W:0]          FOUR    = {3'b001, {(FRAC_BITS+2){1'b0}}};

    mbp_pkg::state_t state_reg, state_next;

    logic signed [DW-1:0] dx_reg, dx_next;
    logic signed [DW-1:0] dy_reg, dy_next;
    logic signed [W-1:0]  cr_reg, cr_next;
    logic signed [W-1:0]  ci_reg, ci_next;
    logic signed [W-1:0]  zr_reg, zr_next;
    logic signed [W-1:0]  zi_reg, zi_next;
    logic signed [W-1:0]  rr_reg, rr_next;
    logic [CW-1:0]        n_reg, n_next;
    logic [CW-1:0]        lim_reg, lim_next;

    logic [MA-1:0]          mul_a, mul_b;
    mbp_pkg::mul_ctl_t      mul_ctl;
    logic signed [W-1:0]    mul_res;
    logic [3*mbp_pkg::COLOR_W-1:0] pal_q;

    logic [mbp_pkg::PIX_W-1:0] px, py;
    logic [W-1:0]         zr_abs, zi_abs;
    logic [DW-1:0]        dx_abs, dy_abs;
    logic                 at_limit;
    logic                 out_of_range;
    logic                 mag_escape;
    logic signed [W+1:0]  re_sum, im_sum;

    function automatic logic signed [W-1:0] sat_z(input logic signed [W+1:0] v);
        if (v > (W+2)'(Z_MAX)) begin
            return Z_MAX;
        end else if (v < (W+2)'(Z_MIN)) begin
            return Z_MIN;
        end
        return W'(v);
    endfunction

    mbp_mul_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .aclk  (aclk),
        .a_mag (mul_a),
        .b_mag (mul_b),
        .ctl   (mul_ctl),
        .res   (mul_res)
    );

    mbp_palette_rom #(
        .DEPTH (ITER_LIMIT_MAX),
        .AW    (IW)
    ) u_rom (
        .aclk    (aclk),
        .addr    (IW'(n_reg)),
        .rd_data (pal_q)
    );

    assign px = ({3'b000, x_pixel} > 13'(PIX_MAX)) ? mbp_pkg::PIX_W'(PIX_MAX) : x_pixel;
    assign py = ({3'b000, y_pixel} > 13'(PIX_MAX)) ? mbp_pkg::PIX_W'(PIX_MAX) : y_pixel;

    assign zr_abs = zr_reg[W-1] ? W'(-zr_reg) : W'(zr_reg);
    assign zi_abs = zi_reg[W-1] ? W'(-zi_reg) : W'(zi_reg);
    assign dx_abs = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
    assign dy_abs = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);

    assign at_limit     = n_reg >= lim_reg;
    assign out_of_range = zr_reg >= TWO || zr_reg <= NEG_TWO ||
                          zi_reg >= TWO || zi_reg <= NEG_TWO;
    assign mag_escape   = ({1'b0, rr_reg} + {1'b0, mul_res}) >= FOUR;

    assign re_sum = (W+2)'(rr_reg) - (W+2)'(mul_res) + (W+2)'(cr_reg);
    assign im_sum = ((W+2)'(mul_res) <<< 1) + (W+2)'(ci_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mbp_pkg::ST_IDLE:  if (start) state_next = mbp_pkg::ST_MAP_X;
            mbp_pkg::ST_MAP_X: state_next = mbp_pkg::ST_MAP_Y;
            mbp_pkg::ST_MAP_Y: state_next = mbp_pkg::ST_MAP_W;
            mbp_pkg::ST_MAP_W: state_next = mbp_pkg::ST_TEST;
            mbp_pkg::ST_TEST: begin
                state_next = (at_limit || out_of_range) ? mbp_pkg::ST_DONE : mbp_pkg::ST_SQ_I;
            end
            mbp_pkg::ST_SQ_I:  state_next = mbp_pkg::ST_CROSS;
            mbp_pkg::ST_CROSS: begin
                state_next = mag_escape ? mbp_pkg::ST_DONE : mbp_pkg::ST_UPD;
            end
            mbp_pkg::ST_UPD:   state_next = mbp_pkg::ST_TEST;
            mbp_pkg::ST_DONE:  if (res_ready) state_next = mbp_pkg::ST_IDLE;
            default:           state_next = mbp_pkg::ST_IDLE;
        endcase
    end

    // datapath control and register updates
    always_comb begin
        dx_next  = dx_reg;
        dy_next  = dy_reg;
        cr_next  = cr_reg;
        ci_next  = ci_reg;
        zr_next  = zr_reg;
        zi_next  = zi_reg;
        rr_next  = rr_reg;
        n_next   = n_reg;
        lim_next = lim_reg;
        mul_a    = MA'(zr_abs);
        mul_b    = MA'(zr_abs);
        mul_ctl  = '{neg: 1'b0, map_mode: 1'b0};
        case (state_reg)
            mbp_pkg::ST_IDLE: begin
                dx_next  = $signed({1'b0, px}) - $signed({1'b0, x_origin});
                dy_next  = $signed({1'b0, py}) - $signed({1'b0, y_origin});
                lim_next = ({2'b00, max_iter} > 10'(LIM_MAX)) ? CW'(LIM_MAX) : CW'(max_iter);
            end
            mbp_pkg::ST_MAP_X: begin
                mul_a   = MA'(dx_abs);
                mul_b   = MA'(step);
                mul_ctl = '{neg: dx_reg[DW-1], map_mode: 1'b1};
            end
            mbp_pkg::ST_MAP_Y: begin
                cr_next = mul_res;
                mul_a   = MA'(dy_abs);
                mul_b   = MA'(step);
                mul_ctl = '{neg: dy_reg[DW-1], map_mode: 1'b1};
            end
            mbp_pkg::ST_MAP_W: begin
                ci_next = mul_res;
                zr_next = '0;
                zi_next = '0;
                n_next  = '0;
            end
            mbp_pkg::ST_TEST: begin
                mul_a = MA'(zr_abs);
                mul_b = MA'(zr_abs);
            end
            mbp_pkg::ST_SQ_I: begin
                rr_next = mul_res;
                mul_a   = MA'(zi_abs);
                mul_b   = MA'(zi_abs);
            end
            mbp_pkg::ST_CROSS: begin
                // issue re*im before zr is overwritten
                mul_a   = MA'(zr_abs);
                mul_b   = MA'(zi_abs);
                mul_ctl = '{neg: zr_reg[W-1] ^ zi_reg[W-1], map_mode: 1'b0};
                if (!mag_escape) begin
                    zr_next = sat_z(re_sum);
                end
            end
            mbp_pkg::ST_UPD: begin
                zi_next = sat_z(im_sum);
                n_next  = n_reg + 1'b1;
            end
            mbp_pkg::ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mbp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        cr_reg  <= cr_next;
        ci_reg  <= ci_next;
        zr_reg  <= zr_next;
        zi_reg  <= zi_next;
        rr_reg  <= rr_next;
        n_reg   <= n_next;
        lim_reg <= lim_next;
    end

    assign idle      = state_reg == mbp_pkg::ST_IDLE;
    assign res_valid = state_reg == mbp_pkg::ST_DONE;

    always_comb begin
        result.iterations = mbp_pkg::ITER_W'(n_reg);
        result.in_set     = at_limit;
        if (at_limit) begin
            result.red   = mbp_pkg::IN_SET_RED;
            result.green = mbp_pkg::IN_SET_GREEN;
            result.blue  = mbp_pkg::IN_SET_BLUE;
        end else begin
            result.red   = pal_q[mbp_pkg::COLOR_W-1:0];
            result.green = pal_q[2*mbp_pkg::COLOR_W-1:mbp_pkg::COLOR_W];
            result.blue  = pal_q[3*mbp_pkg::COLOR_W-1:2*mbp_pkg::COLOR_W];
        end
    end

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mbp_pkg::ST_TEST || state_reg == mbp_pkg::ST_SQ_I ||
         state_reg == mbp_pkg::ST_CROSS || state_reg == mbp_pkg::ST_UPD ||
         state_reg == mbp_pkg::ST_DONE) |-> n_reg <= lim_reg)
        else $error("iteration count passed the limit");

    a_square_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mbp_pkg::ST_TEST && state_next == mbp_pkg::ST_SQ_I) |->
        (zr_reg < TWO && zr_reg > NEG_TWO && zi_reg < TWO && zi_reg > NEG_TWO))
        else $error("squaring started on an escaped point");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mbp_pkg::ST_UPD |=> n_reg == CW'($past(n_reg) + 1'b1))
        else $error("iteration count did not advance by one");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == mbp_pkg::ST_IDLE)
        else $error("pixel accepted while busy");

endmodule

`default_nettype wire

// ----- tb/mandelbrot_pixel_shader_tb.sv -----
`timescale 1ns / 1ps

class mandel_color_board;
    localparam longint Q_HI   = 64'sh7FFF_FFFF;
    localparam longint Q_LO   = -64'sh8000_0000;
    localparam longint TWO_Q  = 64'sh2000_0000;
    localparam longint FOUR_Q = 64'sh4000_0000;

    logic [9:0]  x_org;
    logic [9:0]  y_org;
    logic [27:0] step_q;
    logic [7:0]  iter_lim;
    logic [7:0]  pal_rgb [255][3];
    mbp_pkg::result_t pending_colors [$];
    int errors;
    int checked;

    function new();
        longint unsigned ph;
        x_org    = mbp_pkg::X_ORIGIN_RST;
        y_org    = mbp_pkg::Y_ORIGIN_RST;
        step_q   = mbp_pkg::STEP_RST;
        iter_lim = mbp_pkg::MAX_ITER_RST;
        errors   = 0;
        checked  = 0;
        for (int k = 0; k < 255; k++) begin
            for (int m = 0; m < 3; m++) begin
                ph = k * mbp_pkg::PAL_STEP + m * mbp_pkg::THIRD_TURN;
                pal_rgb[k][m] = sine_level(ph[31:0]);
            end
        end
    endfunction

    // phase in turns (Q32), folded into the first quadrant
    function logic [7:0] sine_level(logic [31:0] phase);
        longint unsigned frac;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned mag;
        longint unsigned divs [5];
        divs = '{110, 72, 42, 20, 6};
        frac = phase[30] ? mbp_pkg::ONE_Q30 - phase[29:0] : phase[29:0];
        x = (frac * mbp_pkg::HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t = mbp_pkg::ONE_Q30;
        foreach (divs[i]) begin
            t = mbp_pkg::ONE_Q30 - ((x2 * t) >> 30) / divs[i];
        end
        t = (x * t) >> 30;
        if (t > mbp_pkg::ONE_Q30) begin
            t = mbp_pkg::ONE_Q30;
        end
        mag = (t * 127) >> 30;
        return phase[31] ? 8'(127 - mag) : 8'(127 + mag);
    endfunction

    function longint clamp_q(longint v);
        return v > Q_HI ? Q_HI : (v < Q_LO ? Q_LO : v);
    endfunction

    // truncate the product toward zero
    function longint frac_mul(longint a, longint b);
        longint unsigned ua;
        longint unsigned ub;
        longint unsigned p;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        p = (ua * ub) >> 28;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function longint map_axis(logic [9:0] pix, logic [9:0] org);
        longint d;
        d = longint'(pix) - longint'(org);
        return clamp_q(d * longint'(step_q));
    endfunction

    function mbp_pkg::result_t escape_color(logic [9:0] px, logic [9:0] py);
        mbp_pkg::result_t res;
        longint cr;
        longint ci;
        longint zr;
        longint zi;
        longint rr;
        longint ii;
        longint ri;
        int n;
        int lim;
        cr = map_axis(px, x_org);
        ci = map_axis(py, y_org);
        zr = 0;
        zi = 0;
        n = 0;
        lim = iter_lim;
        while (n < lim) begin
            if (zr >= TWO_Q || zr <= -TWO_Q || zi >= TWO_Q || zi <= -TWO_Q) break;
            rr = frac_mul(zr, zr);
            ii = frac_mul(zi, zi);
            if (rr + ii >= FOUR_Q) break;
            ri = frac_mul(zr, zi);
            zr = clamp_q(rr - ii + cr);
            zi = clamp_q(2 * ri + ci);
            n++;
        end
        res.iterations = 8'(n);
        if (n >= lim) begin
            res.in_set = 1'b1;
            res.red    = mbp_pkg::IN_SET_RED;
            res.green  = mbp_pkg::IN_SET_GREEN;
            res.blue   = mbp_pkg::IN_SET_BLUE;
        end else begin
            res.in_set = 1'b0;
            res.red    = pal_rgb[n][0];
            res.green  = pal_rgb[n][1];
            res.blue   = pal_rgb[n][2];
        end
        return res;
    endfunction

    function void note_pixel(logic [9:0] px, logic [9:0] py);
        pending_colors.push_back(escape_color(px, py));
    endfunction

    function int pending();
        return pending_colors.size();
    endfunction

    task set_reg(logic [mbp_pkg::CFG_IDX_W-1:0] idx, logic [mbp_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            mbp_pkg::REG_X_ORIGIN: x_org = val[9:0];
            mbp_pkg::REG_Y_ORIGIN: y_org = val[9:0];
            mbp_pkg::REG_STEP:     step_q = val[27:0];
            mbp_pkg::REG_MAX_ITER: iter_lim = val[7:0];
            default: ;
        endcase
    endtask

    task report(string what);
        $display("MISMATCH at %0t: %s", $time, what);
        errors++;
    endtask

    task check_pixel(logic [7:0] iters, logic in_set, logic [7:0] r, logic [7:0] g,
                     logic [7:0] b);
        mbp_pkg::result_t want;
        if (pending_colors.size() == 0) begin
            report($sformatf("unexpected word, iterations %0d", iters));
            return;
        end
        want = pending_colors.pop_front();
        if (iters !== want.iterations)
            report($sformatf("word %0d iterations %0d, want %0d", checked, iters,
                             want.iterations));
        if (in_set !== want.in_set)
            report($sformatf("word %0d in_set %0b, want %0b", checked, in_set, want.in_set));
        if (r !== want.red)
            report($sformatf("word %0d red %0d, want %0d", checked, r, want.red));
        if (g !== want.green)
            report($sformatf("word %0d green %0d, want %0d", checked, g, want.green));
        if (b !== want.blue)
            report($sformatf("word %0d blue %0d, want %0d", checked, b, want.blue));
        checked++;
    endtask
endclass

module mandelbrot_pixel_shader_tb;

    localparam int RANDOM_PIXELS  = 1400;
    localparam int QUIET_LIMIT    = 20000;
    localparam int RX_HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES   = 1100;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic [23:0] s_tdata = '0;
    logic m_tready = 1'b0;
    logic cfg_valid = 1'b0;
    logic [mbp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mbp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    wire s_tready;
    wire m_tvalid;
    wire [31:0] m_tdata;
    wire [0:0] m_tuser;
    wire cfg_ready;

    logic idle_on = 1'b1;
    logic rx_hold = 1'b0;
    int sent = 0;
    int quiet_cycles = 0;

    mandel_color_board board = new();

    always #4 aclk = ~aclk;

    mandelbrot_pixel_shader DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) board.set_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) board.note_pixel(s_tdata[9:0], s_tdata[19:10]);
            if (m_tvalid && m_tready)
                board.check_pixel(m_tdata[7:0], m_tuser[0], m_tdata[15:8], m_tdata[23:16],
                                  m_tdata[31:24]);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (rx_hold) begin
                m_tready = 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge aclk);
                rx_hold = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 16)) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (board.pending() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(logic [mbp_pkg::CFG_IDX_W-1:0] idx,
                             logic [mbp_pkg::CFG_DATA_W-1:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic configure(logic [9:0] xo, logic [9:0] yo, logic [27:0] st, logic [7:0] mi);
        wait_drained();
        write_reg(mbp_pkg::REG_X_ORIGIN, mbp_pkg::CFG_DATA_W'(xo));
        write_reg(mbp_pkg::REG_Y_ORIGIN, mbp_pkg::CFG_DATA_W'(yo));
        write_reg(mbp_pkg::REG_STEP, mbp_pkg::CFG_DATA_W'(st));
        write_reg(mbp_pkg::REG_MAX_ITER, mbp_pkg::CFG_DATA_W'(mi));
    endtask

    task automatic send_pixel(logic [9:0] x, logic [9:0] y);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_tdata  = {4'd0, y, x};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // bias toward the part of the plane where |c| < 2
    function automatic logic [9:0] pick_coord(logic [9:0] org, int span);
        int v;
        if ($urandom_range(0, 2) == 0) return 10'($urandom_range(0, 1023));
        v = int'(org) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return 10'(v);
    endfunction

    task automatic random_phase(logic long_stall);
        logic [9:0] xo;
        logic [9:0] yo;
        logic [27:0] st;
        logic [7:0] mi;
        int n;
        int span;
        longint unsigned reach;
        xo = 10'($urandom_range(0, 1023));
        yo = 10'($urandom_range(0, 1023));
        case ($urandom_range(0, 9))
            0: st = 28'($urandom_range(1, 28'hFFF_FFFF));
            1: st = 28'($urandom_range(1, 255));
            default: st = 28'($urandom_range(1 << 17, 1 << 21));
        endcase
        case ($urandom_range(0, 9))
            0: begin
                mi = 8'd255;
                n = 8;
            end
            1: begin
                mi = 8'($urandom_range(41, 254));
                n = 20;
            end
            default: begin
                mi = 8'($urandom_range(1, 40));
                n = 70;
            end
        endcase
        configure(xo, yo, st, mi);
        reach = (64'd1 << 29) / st;
        span = reach > 1023 ? 1023 : int'(reach);
        if (long_stall) rx_hold = 1'b1;
        repeat (n) begin
            send_pixel(pick_coord(xo, span), pick_coord(yo, span));
            sent++;
        end
    endtask

    initial begin
        logic stall_done;
        stall_done = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // reset configuration: corners, the origin itself and its neighbor
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd600, 10'd400);
        send_pixel(10'd601, 10'd399);

        // zero limit: no iteration at all
        configure(10'd600, 10'd400, mbp_pkg::STEP_RST, 8'd0);
        send_pixel(10'd600, 10'd400);
        send_pixel(10'd0, 10'd0);

        // zero step: every point maps to c = 0
        configure(10'd0, 10'd1023, 28'd0, 8'd7);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);

        // largest step: c saturates at the format limits
        configure(10'd0, 10'd0, 28'hFFF_FFFF, 8'd255);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd1, 10'd0);
        configure(10'd1023, 10'd0, 28'hFFF_FFFF, 8'd1);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);

        // smallest step with the longest limit
        configure(10'd1023, 10'd1023, 28'd1, 8'd255);
        send_pixel(10'd0, 10'd0);

        while (sent < RANDOM_PIXELS) begin
            idle_on = (sent < RANDOM_PIXELS - 200) && ($urandom_range(0, 3) != 0);
            if (!stall_done && sent >= 300) begin
                stall_done = 1'b1;
                idle_on = 1'b1;
                random_phase(1'b1);
            end else begin
                random_phase(1'b0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (board.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
